// File: src/sbts_pkg.sv
// Shared types and codes for the SMBus byte transaction sequencer.
// Holds the beat payload structs, the phase codes and the command codes.
// No dependencies.
package sbts_pkg;

	// Sequencer phases, as reported in the phase field of a result.
	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_WSTART    = 4'd1,
		PH_WTXMODE   = 4'd2,
		PH_WREGSENT  = 4'd3,
		PH_WDATASENT = 4'd4,
		PH_WRESTART  = 4'd5,
		PH_WADDRFLG  = 4'd6,
		PH_WRXMODE   = 4'd7,
		PH_WRXBYTE   = 4'd8
	} phase_t;

	// Transaction kinds.
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_SEND    = 2'd2;
	localparam logic [1:0] OP_RECEIVE = 2'd3;

	// What the controller is told to transmit.
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_ADDRW = 2'd1;
	localparam logic [1:0] KIND_ADDRR = 2'd2;
	localparam logic [1:0] KIND_DATA  = 2'd3;

	// Acknowledge control.
	localparam logic [1:0] ACK_NONE = 2'd0;
	localparam logic [1:0] ACK_ON   = 2'd1;
	localparam logic [1:0] ACK_OFF  = 2'd2;

	// Register map: one register, slave_addr, at word index zero.
	localparam int unsigned PADDR_W    = 3;
	localparam logic        REG_SLAVE  = 1'b0;

	// One input beat: the request and the controller event flags.
	typedef struct packed {
		logic [1:0] mode;
		logic       go;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       start_sent;
		logic       tx_selected;
		logic       byte_sent;
		logic       addr_flag;
		logic       rx_selected;
		logic       byte_received;
		logic [7:0] rx_byte;
	} in_item_t;

	// One result beat: commands for the controller and completion status.
	typedef struct packed {
		logic [3:0] phase;
		logic       cmd_start;
		logic       cmd_stop;
		logic [1:0] tx_kind;
		logic [7:0] tx_byte;
		logic [1:0] ack_change;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic       done_res;
	} out_item_t;

	// Sequencer state carried from one beat to the next.
	typedef struct packed {
		phase_t     phase;
		logic [1:0] op_kind;
		logic [7:0] held_reg;
		logic [7:0] held_data;
	} seq_state_t;

endpackage

// File: src/sbts_in_if.sv
// Input channel of the SMBus byte transaction sequencer.
// Carries valid, ready and one in_item_t payload; depends on sbts_pkg.
interface sbts_in_if;
	import sbts_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

// File: src/sbts_out_if.sv
// Result channel of the SMBus byte transaction sequencer.
// Carries valid, ready and one out_item_t payload; depends on sbts_pkg.
interface sbts_out_if;
	import sbts_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

// File: src/smbus_byte_transaction_sequencer.sv
// SMBus byte transaction sequencer, top level.
// Depends on sbts_pkg, sbts_in_if, sbts_out_if and sbts_step.
//
// Usage: the host drives one beat on in_ch for each poll of the I2C
// controller. A beat carries the event flags and, when go is set while
// idle, the operation, register pointer and write data. Each input beat
// yields exactly one result beat on out_ch with the commands to issue,
// any captured read byte and a done mark. A go while busy is ignored.
// The device address is written over the APB port at byte address zero;
// pready is always high and reads return the stored value.
//
// Throughput is one beat per clock while in_ch is ready: the phase
// transition is a single pass of combinational logic in sbts_step
// between the state register and the result register. A two-entry
// output stage (result register plus skid register) keeps in_ch ready
// while one result waits; in_ch drops ready only when both entries are
// full under a stalled receiver. Reset clears the phase to idle, the
// latched operands, the device address and both output entries.
module smbus_byte_transaction_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	sbts_in_if.sink                       in_ch,
	sbts_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sbts_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import sbts_pkg::*;

	logic [7:0] slave_addr_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	out_item_t  res;
	out_item_t  out_q;
	out_item_t  skid_q;
	logic       out_valid_q;
	logic       skid_valid_q;
	logic       in_fire;
	logic       out_fire;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1] == REG_SLAVE) ? {24'd0, slave_addr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 8'd0;
		end else if (psel && penable && pwrite && pready
				&& paddr[PADDR_W-1] == REG_SLAVE) begin
			slave_addr_q <= pwdata[7:0];
		end
	end

	// Transition logic for one poll.
	sbts_step u_step (
		.cur        (state_q),
		.slave_addr (slave_addr_q),
		.item       (in_ch.data),
		.nxt        (state_nxt),
		.res        (res)
	);

	assign in_ch.ready = !skid_valid_q;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_fire    = out_valid_q && out_ch.ready;

	// Sequencer state advances on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, op_kind: 2'd0, held_reg: 8'd0, held_data: 8'd0};
		end else if (in_fire) begin
			state_q <= state_nxt;
		end
	end

	// Output stage with skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_fire) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (out_fire) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (in_fire && !out_valid_q) begin
			out_q <= res;
		end
		if (in_fire && out_valid_q && !out_fire) begin
			skid_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;
endmodule

// File: src/sbts_step.sv
// Next-state and command logic for one poll of the sequencer.
// Purely combinational; depends on sbts_pkg.
module sbts_step (
	input  sbts_pkg::seq_state_t cur,
	input  logic [7:0]           slave_addr,
	input  sbts_pkg::in_item_t   item,
	output sbts_pkg::seq_state_t nxt,
	output sbts_pkg::out_item_t  res
);
	import sbts_pkg::*;

	logic [7:0] addr_w;
	logic [7:0] addr_r;

	// Direction bit replaces bit zero of the configured address.
	assign addr_w = {slave_addr[7:1], 1'b0};
	assign addr_r = {slave_addr[7:1], 1'b1};

	// One phase move per poll, with the commands for that move.
	always_comb begin
		nxt = cur;
		res = '0;
		case (cur.phase)
			PH_IDLE: begin
				if (item.go) begin
					nxt.op_kind   = item.mode;
					nxt.held_reg  = item.reg_addr;
					nxt.held_data = item.write_data;
					nxt.phase     = PH_WSTART;
					res.cmd_start = 1'b1;
					if (item.mode == OP_READ || item.mode == OP_RECEIVE) begin
						res.ack_change = ACK_ON;
					end
				end
			end
			PH_WSTART: begin
				if (item.start_sent) begin
					if (cur.op_kind == OP_RECEIVE) begin
						res.tx_kind = KIND_ADDRR;
						res.tx_byte = addr_r;
						nxt.phase   = PH_WADDRFLG;
					end else begin
						res.tx_kind = KIND_ADDRW;
						res.tx_byte = addr_w;
						nxt.phase   = PH_WTXMODE;
					end
				end
			end
			PH_WTXMODE: begin
				if (item.tx_selected) begin
					res.tx_kind = KIND_DATA;
					res.tx_byte = cur.held_reg;
					nxt.phase   = PH_WREGSENT;
				end
			end
			PH_WREGSENT: begin
				if (item.byte_sent) begin
					if (cur.op_kind == OP_WRITE) begin
						res.tx_kind = KIND_DATA;
						res.tx_byte = cur.held_data;
						nxt.phase   = PH_WDATASENT;
					end else if (cur.op_kind == OP_READ) begin
						res.cmd_start = 1'b1;
						nxt.phase     = PH_WRESTART;
					end else begin
						res.cmd_stop = 1'b1;
						res.done_res = 1'b1;
						nxt.phase    = PH_IDLE;
					end
				end
			end
			PH_WDATASENT: begin
				if (item.byte_sent) begin
					res.cmd_stop = 1'b1;
					res.done_res = 1'b1;
					nxt.phase    = PH_IDLE;
				end
			end
			PH_WRESTART: begin
				if (item.start_sent) begin
					res.tx_kind = KIND_ADDRR;
					res.tx_byte = addr_r;
					nxt.phase   = PH_WADDRFLG;
				end
			end
			PH_WADDRFLG: begin
				// A single-byte read turns acknowledge off once addressed.
				if (item.addr_flag) begin
					res.ack_change = ACK_OFF;
					nxt.phase      = PH_WRXMODE;
				end
			end
			PH_WRXMODE: begin
				// Stop is requested before the last byte arrives.
				if (item.rx_selected) begin
					res.cmd_stop = 1'b1;
					nxt.phase    = PH_WRXBYTE;
				end
			end
			PH_WRXBYTE: begin
				if (item.byte_received) begin
					res.rx_valid = 1'b1;
					res.rx_data  = item.rx_byte;
					res.done_res = 1'b1;
					nxt.phase    = PH_IDLE;
				end
			end
			default: begin
				nxt.phase = PH_IDLE;
			end
		endcase
		res.phase = nxt.phase;
	end
endmodule

// File: src/sbts_checker.sv
// Port-level checks for the SMBus byte transaction sequencer.
// Depends on sbts_pkg; bound to the top level and fed from its result channel.
module sbts_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                out_valid,
	input  logic                out_ready,
	input  sbts_pkg::out_item_t out_data
);
	import sbts_pkg::*;

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// A finished transaction always leaves the sequencer idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> out_data.phase == PH_IDLE)
		else $error("done reported outside idle phase");

	// A read byte is only delivered as the transaction completes.
	a_rx_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.rx_valid |-> out_data.done_res)
		else $error("read byte without done");

	// Start conditions lead only into a start-wait phase.
	a_start_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.cmd_start |->
			(out_data.phase == PH_WSTART || out_data.phase == PH_WRESTART))
		else $error("start command in wrong phase");

	// No transmit byte is driven without a transmit command.
	a_tx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tx_kind == KIND_NONE |-> out_data.tx_byte == 8'd0)
		else $error("transmit byte without transmit kind");
endmodule

bind smbus_byte_transaction_sequencer sbts_checker u_sbts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
